>>> rtl/core/ipru_pkg.sv
// shared types and constants of the integer pixel replication upscaler
package ipru_pkg;

  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned MaxScaleDef = 16;

  localparam int unsigned ScaleW    = 5;
  localparam int unsigned SrcWidthW = 11;
  localparam int unsigned PixW      = 24;
  localparam int unsigned CfgAddrW  = 1;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned InUserW   = 1;
  localparam int unsigned OutUserW  = 3;

  localparam logic [CfgAddrW-1:0] RegScale    = 1'b0;
  localparam logic [CfgAddrW-1:0] RegSrcWidth = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic {
    OP_SOURCE = 1'b0,
    OP_REPLAY = 1'b1
  } op_e;

  // one accepted item as handed to the result sequencer
  typedef struct packed {
    logic              err;
    logic              use_mem;
    logic [ScaleW-1:0] pix_left;
    logic [1:0]        pad_left;
    logic              row_end;
  } job_t;

endpackage

>>> rtl/core/integer_pixel_replication_upscaler.sv
// Nearest-neighbor integer upscaler for 24-bit pixels. Source pixels (tuser 0) are written to
// a single-port line store and emitted scale times; replay items (tuser 1) read the next stored
// pixel back for the remaining scale-1 rows. After each output row (width*scale) mod 4 zero pad
// results follow. An item in the wrong phase yields one error result and changes no state.
// An item yields scale + pads results (1 to 19), an error item one, at one result per cycle
// unless the output stalls, as the result sequencer sets; the next item is taken in the cycle
// its predecessor hands over its final result, so items follow without gaps. Results pass the
// job and output registers. The line store needs no clearing after reset. Configuration is
// taken at any time, one write per cycle, but should change only while the block is idle.
module integer_pixel_replication_upscaler
  import ipru_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  parameter int unsigned MAX_SCALE = MaxScaleDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // blue, green, red
  input  logic [InUserW-1:0]  s_axis_tuser,   // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // out_blue, out_green, out_red
  output logic [OutUserW-1:0] m_axis_tuser,   // kind[1:0], last[2]
  output logic                m_axis_tlast    // row_end
);

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CopyW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [ScaleW-1:0]    scale_q, scale_d;
  logic [SrcWidthW-1:0] src_width_q, src_width_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [CopyW-1:0]     copies_q, copies_d;

  logic [PixW-1:0] line_mem [MAX_WIDTH];
  logic [PixW-1:0] rd_q;

  logic                 accept;
  logic                 free;
  op_e                  op;
  logic                 phase_err;
  logic                 row_done;
  logic [ScaleW-1:0]    eff_scale;
  logic [SrcWidthW-1:0] eff_width;
  logic [3:0]           pad_prod;
  job_t                 job;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser[0]);

  always_comb begin
    scale_d     = scale_q;
    src_width_d = src_width_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        RegScale:    scale_d     = cfg_data_i[ScaleW-1:0];
        RegSrcWidth: src_width_d = cfg_data_i[SrcWidthW-1:0];
        default:     ;
      endcase
    end
  end

  // clamp registers to the supported range
  always_comb begin
    if (scale_q == '0) begin
      eff_scale = ScaleW'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      eff_scale = ScaleW'(MAX_SCALE);
    end else begin
      eff_scale = scale_q;
    end
    if (src_width_q == '0) begin
      eff_width = SrcWidthW'(1);
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      eff_width = SrcWidthW'(MAX_WIDTH);
    end else begin
      eff_width = src_width_q;
    end
  end

  assign phase_err = (op == OP_SOURCE) != (copies_q == '0);
  assign row_done  = (32'(col_q) + 32'd1) >= 32'(eff_width);
  // only the low two bits of width and scale matter for the pad count
  assign pad_prod  = 4'(eff_width[1:0]) * 4'(eff_scale[1:0]);

  always_comb begin
    job.err      = phase_err;
    job.use_mem  = (op == OP_REPLAY);
    job.pix_left = eff_scale;
    job.pad_left = row_done ? pad_prod[1:0] : 2'd0;
    job.row_end  = row_done;
  end

  always_comb begin
    col_d    = col_q;
    copies_d = copies_q;
    if (accept && !phase_err) begin
      if (row_done) begin
        col_d = '0;
        if (op == OP_SOURCE) begin
          copies_d = CopyW'(eff_scale - ScaleW'(1));
        end else begin
          copies_d = copies_q - CopyW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ScaleW'(1);
      src_width_q <= SrcWidthW'(1);
      col_q       <= '0;
      copies_q    <= '0;
    end else begin
      scale_q     <= scale_d;
      src_width_q <= src_width_d;
      col_q       <= col_d;
      copies_q    <= copies_d;
    end
  end

  // line store: source items write, replay items read; each in-phase item touches it at its accept edge
  always_ff @(posedge clk_i) begin
    if (accept && !phase_err) begin
      if (op == OP_SOURCE) begin
        line_mem[col_q] <= s_axis_tdata;
      end else begin
        rd_q <= line_mem[col_q];
      end
    end
  end

  ipru_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .job_i         (job),
    .px_i          (s_axis_tdata),
    .mem_px_i      (rd_q),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH)
    else $error("column outside the line store");

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_err) |=> ($stable(col_q) && $stable(copies_q)))
    else $error("out of phase item changed state");

  a_copies_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(copies_q) < MAX_SCALE)
    else $error("replay row count above scale");
`endif

endmodule

>>> rtl/core/ipru_emit.sv
// result sequencer: expands one item into pixel copies and zero pad results, or one error result
module ipru_emit
  import ipru_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  job_t                job_i,
  input  logic [PixW-1:0]     px_i,
  input  logic [PixW-1:0]     mem_px_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,  // out_blue, out_green, out_red
  output logic [OutUserW-1:0] m_axis_tuser,  // kind[1:0], last[2]
  output logic                m_axis_tlast   // row_end
);

  logic            job_valid_q, job_valid_d;
  job_t            job_q, job_d;
  logic [PixW-1:0] px_q;

  logic            out_valid_q, out_valid_d;
  logic [PixW-1:0] out_data_q, out_data_d;
  kind_e           out_kind_q, out_kind_d;
  logic            out_last_q, out_last_d;
  logic            out_row_q, out_row_d;

  logic  advance;
  logic  cur_last;
  logic  cur_row;
  kind_e cur_kind;
  logic [PixW-1:0] cur_data;

  assign advance = job_valid_q && (!out_valid_q || m_axis_tready);

  // what the job shows this cycle
  always_comb begin
    cur_data = '0;
    if (job_q.err) begin
      cur_kind = KIND_ERROR;
      cur_last = 1'b1;
      cur_row  = 1'b0;
    end else if (job_q.pix_left != '0) begin
      cur_kind = KIND_PIXEL;
      cur_data = job_q.use_mem ? mem_px_i : px_q;
      cur_last = (job_q.pix_left == ScaleW'(1)) && (job_q.pad_left == 2'd0);
      cur_row  = cur_last && job_q.row_end;
    end else begin
      cur_kind = KIND_PAD;
      cur_last = (job_q.pad_left == 2'd1);
      cur_row  = cur_last;
    end
  end

  assign free_o = !job_valid_q || (advance && cur_last);

  always_comb begin
    job_valid_d = job_valid_q;
    job_d       = job_q;
    if (advance) begin
      if (cur_last) begin
        job_valid_d = 1'b0;
      end else if (job_q.pix_left != '0) begin
        job_d.pix_left = job_q.pix_left - ScaleW'(1);
      end else begin
        job_d.pad_left = job_q.pad_left - 2'd1;
      end
    end
    if (load_i) begin
      job_valid_d = 1'b1;
      job_d       = job_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_row_d   = out_row_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = cur_data;
      out_kind_d  = cur_kind;
      out_last_d  = cur_last;
      out_row_d   = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
    out_row_q  <= out_row_d;
    if (load_i) begin
      px_q <= px_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_last_q, out_kind_q};
  assign m_axis_tlast  = out_row_q;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("item loaded over an unfinished job");

  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !job_q.err) |-> (job_q.pix_left != '0 || job_q.pad_left != 2'd0))
    else $error("live job has nothing left to emit");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_ERROR) |-> (out_last_q && !out_row_q))
    else $error("error result must be alone and not end a row");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KIND_PIXEL) |-> (out_data_q == '0))
    else $error("non-pixel result carries pixel bytes");

  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_row_q) |-> out_last_q)
    else $error("row end on a result that does not close its item");
`endif

endmodule

>>> tb/sv/integer_pixel_replication_upscaler_test.sv
// testbench of the integer pixel replication upscaler: streams pixels, predicts results
`timescale 1ns / 1ps

module integer_pixel_replication_upscaler_test;
  import ipru_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] px;
    logic        row_end;
    logic        last;
  } upscaled_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata;   // blue, green, red
  logic [InUserW-1:0]  s_axis_tuser;   // op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [PixW-1:0]     m_axis_tdata;   // out_blue, out_green, out_red
  logic [OutUserW-1:0] m_axis_tuser;   // kind[1:0], last[2]
  logic                m_axis_tlast;   // row_end

  // predictor state
  logic [23:0]   stored_row [MaxWidthDef];
  int unsigned   col_pos;
  int unsigned   rows_owed;
  logic [4:0]    scale_reg;
  logic [10:0]   width_reg;
  upscaled_t     owed_results [$];
  int unsigned   mismatch_count;

  // sender state
  int unsigned   burst_left;
  bit            sender_up;
  int unsigned   random_items;

  // receiver stall pattern
  int unsigned   stall_left;
  int unsigned   calm_left;

  integer_pixel_replication_upscaler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > MaxScaleDef) return MaxScaleDef;
    return scale_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return width_reg;
  endfunction

  function automatic void upscale_item(op_e op, logic [23:0] px_in);
    int unsigned s;
    int unsigned w;
    int unsigned pads;
    bit          row_done;
    logic [23:0] px;
    s = eff_scale();
    w = eff_width();
    if ((op == OP_SOURCE) != (rows_owed == 0)) begin
      owed_results.push_back('{KIND_ERROR, 24'h0, 1'b0, 1'b1});
      return;
    end
    if (op == OP_SOURCE) begin
      stored_row[col_pos] = px_in;
      px = px_in;
    end else begin
      px = stored_row[col_pos];
    end
    row_done = (col_pos + 1 >= w);
    pads = row_done ? (w * s) % 4 : 0;
    for (int unsigned i = 0; i < s; i++) begin
      owed_results.push_back('{KIND_PIXEL, px,
                               (i + 1 == s) && (pads == 0) && row_done,
                               (i + 1 == s) && (pads == 0)});
    end
    for (int unsigned i = 0; i < pads; i++) begin
      owed_results.push_back('{KIND_PAD, 24'h0, i + 1 == pads, i + 1 == pads});
    end
    if (row_done) begin
      col_pos = 0;
      rows_owed = (op == OP_SOURCE) ? s - 1 : rows_owed - 1;
    end else begin
      col_pos++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    upscaled_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: tuser %0h tdata %06h tlast %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (m_axis_tuser[1:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser[1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[7:0] !== want.px[7:0]) begin
          $error("out_blue: expected %0h, got %0h", want.px[7:0], m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:8] !== want.px[15:8]) begin
          $error("out_green: expected %0h, got %0h", want.px[15:8], m_axis_tdata[15:8]);
          mismatch_count++;
        end
        if (m_axis_tdata[23:16] !== want.px[23:16]) begin
          $error("out_red: expected %0h, got %0h", want.px[23:16], m_axis_tdata[23:16]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser[2] !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tuser[2]);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: short random stalls with occasional calm stretches
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 47) == 0) begin
        calm_left = $urandom_range(20, 120);
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
    end
  end

  task automatic hold_sender();
    if (sender_up) begin
      s_axis_tvalid <= 1'b0;
      sender_up = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic push_pixel_item(op_e op, logic [23:0] px);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(4, 12) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    if (!sender_up) begin
      s_axis_tvalid <= 1'b1;
      sender_up = 1'b1;
    end
    s_axis_tdata <= px;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    upscale_item(op, px);
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      sender_up = 1'b0;
    end
  endtask

  task automatic wait_until_drained();
    hold_sender();
    while (owed_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes both registers back to back, only once the block has gone quiet
  task automatic set_geometry(logic [10:0] scale_data, logic [10:0] width_data);
    wait_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= RegScale;
    cfg_data_i  <= scale_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    scale_reg = scale_data[4:0];
    cfg_addr_i <= RegSrcWidth;
    cfg_data_i <= width_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_reg = width_data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_wrong_phase();
    push_pixel_item(rows_owed == 0 ? OP_REPLAY : OP_SOURCE, 24'($urandom));
  endtask

  task automatic send_row(op_e op);
    for (int unsigned i = 0; i < eff_width(); i++) begin
      if ($urandom_range(0, 19) == 0) send_wrong_phase();
      if ($urandom_range(0, 99) == 0) wait_until_drained();
      push_pixel_item(op, 24'($urandom));
      random_items++;
    end
  endtask

  task automatic test_reset_state();
    push_pixel_item(OP_REPLAY, 24'h123456);
    push_pixel_item(OP_SOURCE, 24'hFFFFFF);
    push_pixel_item(OP_SOURCE, 24'h000000);
  endtask

  task automatic test_phase_errors();
    set_geometry(11'd3, 11'd2);
    push_pixel_item(OP_SOURCE, 24'hA5A55A);
    push_pixel_item(OP_SOURCE, 24'h5A5AA5);
    push_pixel_item(OP_SOURCE, 24'hFF00FF);
    repeat (4) push_pixel_item(OP_REPLAY, 24'h00FF00);
    push_pixel_item(OP_REPLAY, 24'hFFFFFF);
  endtask

  task automatic test_clamped_config();
    // both registers zero in their used bits, so both act as one
    set_geometry(11'h7E0, 11'd0);
    push_pixel_item(OP_SOURCE, 24'h0F0F0F);
  endtask

  task automatic test_mid_row_config();
    set_geometry(11'd2, 11'd4);
    repeat (3) push_pixel_item(OP_SOURCE, 24'($urandom));
    // column already past the new width, so the next item closes the row
    set_geometry(11'd2, 11'd2);
    push_pixel_item(OP_SOURCE, 24'($urandom));
    repeat (2) push_pixel_item(OP_REPLAY, 24'($urandom));
    push_pixel_item(OP_SOURCE, 24'($urandom));
    set_geometry(11'd2, 11'd3);
    repeat (2) push_pixel_item(OP_SOURCE, 24'($urandom));
    repeat (3) push_pixel_item(OP_REPLAY, 24'($urandom));
  endtask

  task automatic test_full_width_row();
    // width above the store depth acts as the full store, so a long row stays open
    set_geometry(11'd1, 11'h7FF);
    repeat (150) push_pixel_item(OP_SOURCE, 24'($urandom));
    // narrowing to the current column closes the row on the next item
    set_geometry(11'd1, 11'd151);
    push_pixel_item(OP_SOURCE, 24'($urandom));
  endtask

  task automatic test_random_images();
    int unsigned pick;
    int unsigned s;
    logic [4:0]  scale_bits;
    logic [10:0] width_data;
    while (random_items < 260) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) scale_bits = 5'd0;
      else if (pick == 1) scale_bits = 5'($urandom_range(17, 31));
      else if (pick <= 4) scale_bits = 5'($urandom_range(5, 16));
      else scale_bits = 5'($urandom_range(1, 4));
      s = (scale_bits == 0) ? 1 : (scale_bits > MaxScaleDef ? MaxScaleDef : scale_bits);
      width_data = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 48 / s));
      set_geometry({6'($urandom_range(0, 63)), scale_bits}, width_data);
      repeat ($urandom_range(1, 3)) begin
        send_row(OP_SOURCE);
        for (int unsigned r = 1; r < s; r++) send_row(OP_REPLAY);
      end
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= RegScale;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_SOURCE;
    m_axis_tready <= 1'b0;
    col_pos        = 0;
    rows_owed      = 0;
    scale_reg      = 5'd1;
    width_reg      = 11'd1;
    mismatch_count = 0;
    burst_left     = 0;
    sender_up      = 1'b0;
    random_items   = 0;
    stall_left     = 0;
    calm_left      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_phase_errors();
    test_clamped_config();
    test_mid_row_config();
    test_full_width_row();
    test_random_images();

    hold_sender();
    guard = 0;
    while (owed_results.size() > 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (owed_results.size() > 0) begin
      $error("%0d results never arrived", owed_results.size());
      mismatch_count++;
    end
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("integer_pixel_replication_upscaler_test OK");
    end else begin
      $display("integer_pixel_replication_upscaler_test NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("integer_pixel_replication_upscaler_test NOT OK");
    $finish;
  end

endmodule
